### rtl/rtt_pkg.sv
package rtt_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int CHAR_W   = 8;
   localparam int RADIX_W  = 7;
   localparam int DIGIT_W  = 6;
   localparam int STATUS_W = 2;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 7'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 7'd64;
   localparam logic [RADIX_W-1:0] RADIX_CASE  = 7'd36;
   localparam logic [RADIX_W-1:0] RADIX_FOLD  = 7'd38;

   localparam logic [6:0] CH_DOT = 7'h2e;
   localparam logic [6:0] CH_0   = 7'h30;
   localparam logic [6:0] CH_9   = 7'h39;
   localparam logic [6:0] CH_UA  = 7'h41;
   localparam logic [6:0] CH_UZ  = 7'h5a;
   localparam logic [6:0] CH_LA  = 7'h61;

   // shifts that close the gaps between the character groups
   localparam logic [6:0] SHIFT_UPPER      = CH_UA - CH_9 - 7'd1;
   localparam logic [6:0] SHIFT_LOWER_FOLD = CH_LA - CH_9 - 7'd1;
   localparam logic [6:0] SHIFT_LOWER      = (CH_LA - CH_UZ - 7'd1) + SHIFT_UPPER;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ERROR    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic               valid;
      logic [DIGIT_W-1:0] value;
   } digit_type;

   typedef struct packed {
      logic go;
      logic last;
   } step_type;

endpackage

### rtl/radix_text_to_integer.sv
// channel | dir | tdata                  | tuser           | tlast
// req     | in  | [7:0] char_code        | -               | end_of_text
// rsp     | out | [RSP_DATA_W-1:0] value | [1:0] status    | -
// csr     | in  | [6:0] radix, written when csr_we is high
//
// one word per cycle sustained while no terminator waits on a stalled result; a word is
// held in the input register, then feeds the multiply-add by the radix or the result register.
// the accumulator loop (value * radix + digit, overflow check) sets the cycle.
// reset clears the state and the radix returns to 10.
// a stalled result holds back a terminator word and the words behind it;
// characters alone pass a stalled result.
module radix_text_to_integer #(
   parameter int VALUE_WIDTH = rtt_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rtt_pkg::CHAR_W-1:0]            req_tdata,   // char_code
   input  logic                                  req_tlast,   // end_of_text
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((VALUE_WIDTH+7)/8)*8-1:0]      rsp_tdata,   // number_value
   output logic [rtt_pkg::STATUS_W-1:0]          rsp_tuser,   // parse_status
   input  logic                                  csr_we,
   input  logic [rtt_pkg::RADIX_W-1:0]           csr_wdata    // radix
);
   import rtt_pkg::*;

   localparam int RSP_DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

   logic [RADIX_W-1:0] radix_ff;

   logic              s1_valid_ff, s1_valid_in;
   logic [CHAR_W-1:0] s1_char_ff;
   logic              s1_last_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   status_type             rsp_status_ff;

   logic                   out_free;
   logic                   s1_move;
   logic                   load_rsp;
   step_type               step;
   digit_type              digit;
   logic [VALUE_WIDTH-1:0] result_value;
   status_type             result_status;

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      s1_move      = s1_valid_ff && (!s1_last_ff || out_free);
      req_tready   = !s1_valid_ff || s1_move;
      load_rsp     = s1_move && s1_last_ff;
      step.go      = s1_move;
      step.last    = s1_last_ff;
      s1_valid_in  = (req_tvalid && req_tready) || (s1_valid_ff && !s1_move);
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   rtt_digit u_digit (
      .char_code (s1_char_ff),
      .radix     (radix_ff),
      .digit     (digit)
   );

   rtt_accum #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_accum (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .digit  (digit),
      .radix  (radix_ff),
      .value  (result_value),
      .status (result_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= RADIX_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            radix_ff <= csr_wdata;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_char_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (load_rsp) begin
         rsp_value_ff  <= result_value;
         rsp_status_ff <= result_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_value_ff);
   assign rsp_tuser  = rsp_status_ff;

endmodule

### rtl/rtt_digit.sv
module rtt_digit (
   input  logic [rtt_pkg::CHAR_W-1:0]  char_code,
   input  logic [rtt_pkg::RADIX_W-1:0] radix,
   output rtt_pkg::digit_type          digit
);
   import rtt_pkg::*;

   logic [6:0] c;
   logic [6:0] mapped;
   logic [6:0] offset;
   logic [6:0] diff;
   logic       ok;

   always_comb begin
      c      = char_code[6:0];
      ok     = !char_code[7];
      mapped = c;
      if (c >= CH_LA) begin
         mapped = (radix <= RADIX_FOLD) ? c - SHIFT_LOWER_FOLD : c - SHIFT_LOWER;
      end else if (c > CH_UZ) begin
         ok = 1'b0;
      end else if (c >= CH_UA) begin
         mapped = c - SHIFT_UPPER;
      end else if (c > CH_9) begin
         ok = 1'b0;
      end
      offset = (radix > RADIX_CASE) ? CH_DOT : CH_0;
      diff   = mapped - offset;
      if (mapped < offset) begin
         ok = 1'b0;
      end
      if (diff >= radix) begin
         ok = 1'b0;
      end
      digit.valid = ok;
      digit.value = diff[DIGIT_W-1:0];
   end

endmodule

### rtl/rtt_accum.sv
module rtt_accum #(
   parameter int VALUE_WIDTH = rtt_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rtt_pkg::step_type           step,
   input  rtt_pkg::digit_type          digit,
   input  logic [rtt_pkg::RADIX_W-1:0] radix,
   output logic [VALUE_WIDTH-1:0]      value,
   output rtt_pkg::status_type         status
);
   import rtt_pkg::*;

   localparam int PROD_W = VALUE_WIDTH + RADIX_W;

   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   seen_ff, seen_in;
   status_type             fault_ff, fault_in;

   logic [PROD_W-1:0] mac;
   logic              overflow;
   logic              radix_ok;

   always_comb begin
      radix_ok = radix inside {[RADIX_MIN:RADIX_MAX]};
      mac      = PROD_W'(acc_ff) * PROD_W'(radix) + PROD_W'(digit.value);
      overflow = |mac[PROD_W-1:VALUE_WIDTH];
   end

   // result of a terminator, built from the state before it clears
   always_comb begin
      if (fault_ff != STATUS_OK) begin
         status = fault_ff;
      end else if (!radix_ok || !seen_ff) begin
         status = STATUS_ERROR;
      end else begin
         status = STATUS_OK;
      end
      value = (status == STATUS_OK) ? acc_ff : '0;
   end

   always_comb begin
      acc_in   = acc_ff;
      seen_in  = seen_ff;
      fault_in = fault_ff;
      if (step.go && step.last) begin
         acc_in   = '0;
         seen_in  = 1'b0;
         fault_in = STATUS_OK;
      end else if (step.go && fault_ff == STATUS_OK) begin
         if (!radix_ok || !digit.valid) begin
            fault_in = STATUS_ERROR;
         end else if (overflow) begin
            fault_in = STATUS_OVERFLOW;
         end else begin
            acc_in  = mac[VALUE_WIDTH-1:0];
            seen_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         seen_ff  <= 1'b0;
         fault_ff <= STATUS_OK;
      end else begin
         acc_ff   <= acc_in;
         seen_ff  <= seen_in;
         fault_ff <= fault_in;
      end
   end

endmodule

### rtl/rtt_checker.sv
module rtt_checker #(
   parameter int VALUE_WIDTH = rtt_pkg::VALUE_WIDTH_DEFAULT
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((VALUE_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   input logic [rtt_pkg::STATUS_W-1:0]        rsp_tuser
);
   import rtt_pkg::*;

   // no result word right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_OK || rsp_tuser == STATUS_ERROR ||
                      rsp_tuser == STATUS_OVERFLOW))
      else $error("undefined status code");

   // a failed parse always reports zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_OK) |-> (rsp_tdata == '0))
      else $error("nonzero value with error status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result word changed");

endmodule

bind radix_text_to_integer rtt_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_rtt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### verif/radix_text_to_integer_tb.sv
`timescale 1ns / 1ps

module radix_text_to_integer_tb;
   import rtt_pkg::*;

   localparam int VALUE_W      = 64;
   localparam int RANDOM_WORDS = 1150;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   localparam int CODE_DOT     = int'(CH_DOT);
   localparam int CODE_ZERO    = int'(CH_0);
   localparam int CODE_UPPER_A = int'(CH_UA);
   localparam int CODE_UPPER_Z = int'(CH_UZ);
   localparam int CODE_LOWER_A = int'(CH_LA);
   localparam int CODE_NINE    = int'(CH_9);
   localparam int BASE_MIN     = int'(RADIX_MIN);
   localparam int BASE_MAX     = int'(RADIX_MAX);
   localparam int BASE_CASE    = int'(RADIX_CASE);
   localparam int BASE_FOLD    = int'(RADIX_FOLD);

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } text_word_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      status_type         status;
   } number_type;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_PULSED
   } ready_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [CHAR_W-1:0]    req_tdata = '0;     // char_code
   logic                 req_tlast = 1'b0;   // end_of_text
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [VALUE_W-1:0]   rsp_tdata;          // number_value
   logic [STATUS_W-1:0]  rsp_tuser;          // parse_status
   logic                 csr_we = 1'b0;
   logic [RADIX_W-1:0]   csr_wdata = '0;     // radix

   text_word_type        pending_words [$];
   number_type           expected_numbers [$];
   text_word_type        next_word;
   logic                 req_taken = 1'b0;
   int                   words_queued = 0;
   int                   error_count = 0;
   int                   cycle_count = 0;
   int                   burst_left = 0;
   int                   gap_left = 0;
   ready_mode_type       ready_mode = READY_ALWAYS;
   int                   ready_left = 0;

   // parser state as seen from outside
   logic [VALUE_W-1:0]   text_acc = '0;
   logic                 text_seen = 1'b0;
   status_type           text_fault = STATUS_OK;
   logic [RADIX_W-1:0]   radix_setting = RADIX_RESET;

   int                   fixed_radix [12] = '{2, 64, 0, 127, 36, 37, 38, 39, 1, 65, 16, 10};

   radix_text_to_integer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int digit_value(logic [CHAR_W-1:0] code, int base);
      int c;
      c = int'(code);
      if (c >= 128) return -1;
      if (c >= CODE_LOWER_A) begin
         if (base <= BASE_FOLD) c -= CODE_LOWER_A - CODE_NINE - 1;
         else c -= (CODE_LOWER_A - CODE_UPPER_Z - 1) + (CODE_UPPER_A - CODE_NINE - 1);
      end else if (c > CODE_UPPER_Z) begin
         return -1;
      end else if (c >= CODE_UPPER_A) begin
         c -= CODE_UPPER_A - CODE_NINE - 1;
      end else if (c > CODE_NINE) begin
         return -1;
      end
      c -= (base > BASE_CASE) ? CODE_DOT : CODE_ZERO;
      if (c < 0 || c >= base) return -1;
      return c;
   endfunction

   // character for a digit, letters in random case where the radix folds case
   function automatic logic [CHAR_W-1:0] char_of_digit(int d, int base);
      int letter_a;
      letter_a = ($urandom_range(0, 1) == 1) ? CODE_LOWER_A : CODE_UPPER_A;
      if (base <= BASE_CASE) begin
         if (d < 10) return 8'(CODE_ZERO + d);
         return 8'(letter_a + d - 10);
      end
      if (d < 2) return 8'(CODE_DOT + d);
      if (d < 12) return 8'(CODE_ZERO + d - 2);
      if (base <= BASE_FOLD) return 8'(letter_a + d - 12);
      if (d < 38) return 8'(CODE_UPPER_A + d - 12);
      return 8'(CODE_LOWER_A + d - 38);
   endfunction

   task automatic note_failure(string msg);
      error_count++;
      if (error_count <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
   endtask

   task automatic apply_word(logic [CHAR_W-1:0] code, logic last);
      int          base;
      int          d;
      logic        base_ok;
      logic [63:0] all_ones;
      number_type  result;
      base = int'(radix_setting);
      base_ok = (base >= BASE_MIN) && (base <= BASE_MAX);
      all_ones = '1;
      if (last) begin
         result.value = '0;
         if (text_fault != STATUS_OK) begin
            result.status = text_fault;
         end else if (!base_ok || !text_seen) begin
            result.status = STATUS_ERROR;
         end else begin
            result.status = STATUS_OK;
            result.value = text_acc;
         end
         expected_numbers.insert(expected_numbers.size(), result);
         text_acc = '0;
         text_seen = 1'b0;
         text_fault = STATUS_OK;
         return;
      end
      if (text_fault != STATUS_OK) return;
      if (!base_ok) begin
         text_fault = STATUS_ERROR;
         return;
      end
      d = digit_value(code, base);
      if (d < 0) begin
         text_fault = STATUS_ERROR;
         return;
      end
      if (text_acc > (all_ones - 64'(d)) / 64'(base)) begin
         text_fault = STATUS_OVERFLOW;
         return;
      end
      text_acc = text_acc * 64'(base) + 64'(d);
      text_seen = 1'b1;
   endtask

   task automatic push_word(logic [CHAR_W-1:0] code, logic last);
      text_word_type w;
      w.code = code;
      w.last = last;
      pending_words.insert(pending_words.size(), w);
      words_queued++;
   endtask

   // one numeral text: mostly well formed, some noise, broken and empty ones
   task automatic make_text(int base, bit terminate);
      int                kind;
      int                len;
      int                full;
      int                eff;
      int                pos;
      logic [71:0]       reach;
      logic [63:0]       val;
      logic [CHAR_W-1:0] digits [$];
      eff = (base >= BASE_MIN && base <= BASE_MAX) ? base : BASE_MAX;
      full = 0;
      reach = 72'd1;
      while (reach < 72'h1_0000_0000_0000_0000) begin
         reach = reach * 72'(eff);
         full++;
      end
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         len = $urandom_range(1, 6);
         repeat (len) push_word(char_of_digit($urandom_range(0, eff - 1), eff), 1'b0);
      end else if (kind < 58) begin
         len = full + $urandom_range(0, 2) - 1;
         repeat (len) push_word(char_of_digit($urandom_range(0, eff - 1), eff), 1'b0);
      end else if (kind < 75) begin
         case ($urandom_range(0, 3))
            0:       val = '1;
            1:       val = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 300));
            2:       val = {$urandom, $urandom};
            default: val = 64'($urandom_range(0, 1000));
         endcase
         do begin
            digits.push_front(char_of_digit(int'(val % 64'(eff)), eff));
            val = val / 64'(eff);
         end while (val != 0);
         if ($urandom_range(0, 3) == 0)
            digits.insert(digits.size(), char_of_digit($urandom_range(0, eff - 1), eff));
         foreach (digits[i]) push_word(digits[i], 1'b0);
      end else if (kind < 85) begin
         len = $urandom_range(1, 5);
         repeat (len) push_word(8'($urandom_range(0, 255)), 1'b0);
      end else if (kind < 93) begin
         len = $urandom_range(2, 8);
         pos = $urandom_range(0, len - 1);
         for (int i = 0; i < len; i++) begin
            if (i == pos) push_word(8'($urandom_range(0, 255)), 1'b0);
            else push_word(char_of_digit($urandom_range(0, eff - 1), eff), 1'b0);
         end
      end
      if (terminate) push_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // characters give no result, so the wait runs on past the empty queues to drain the pipeline
   task automatic wait_idle();
      while (pending_words.size() != 0 || req_tvalid || expected_numbers.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_radix(int value);
      wait_idle();
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = 7'(value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // word driver, bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            next_word = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= next_word.code;
            req_tlast <= next_word.last;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         ready_left = $urandom_range(20, 80);
      end
      ready_left--;
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= ($urandom_range(0, 2) != 0);
         default:      rsp_tready <= ((cycle_count % 11) < 3);
      endcase
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (csr_we) radix_setting = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_numbers.size() == 0) begin
               note_failure($sformatf("unexpected word value %0d status %0d",
                                      rsp_tdata, rsp_tuser));
            end else begin
               if (rsp_tdata !== expected_numbers[0].value)
                  note_failure($sformatf("value mismatch: expected %0d actual %0d",
                                         expected_numbers[0].value, rsp_tdata));
               if (rsp_tuser !== expected_numbers[0].status)
                  note_failure($sformatf("status mismatch: expected %0d actual %0d",
                                         expected_numbers[0].status, rsp_tuser));
               void'(expected_numbers.pop_front());
            end
         end
         if (req_tvalid && req_tready) apply_word(req_tdata, req_tlast);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("radix_text_to_integer_tb failed");
         $finish;
      end
   end

   initial begin
      int base;
      int texts;
      int phase;
      int start;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset radix: zero, empty text, bad digit then ignored, high byte
      push_word(8'(CODE_ZERO), 1'b0);
      push_word(8'h00, 1'b1);
      push_word(8'hff, 1'b1);
      push_word(8'(CODE_ZERO + 7), 1'b0);
      push_word(8'(CODE_LOWER_A), 1'b0);
      push_word(8'(CODE_ZERO + 3), 1'b0);
      push_word(8'h80, 1'b1);
      push_word(8'hff, 1'b0);
      push_word(8'h00, 1'b1);
      // top radix, eleven highest digits overflow
      set_radix(BASE_MAX);
      repeat (11) push_word(8'(CODE_LOWER_A + 25), 1'b0);
      push_word(8'h00, 1'b1);
      // radix out of range
      set_radix(0);
      push_word(8'(CODE_ZERO + 1), 1'b0);
      push_word(8'h00, 1'b1);
      // dot and slash as the two lowest digits
      set_radix(37);
      push_word(8'(CODE_DOT), 1'b0);
      push_word(8'(CODE_DOT + 1), 1'b0);
      push_word(8'h00, 1'b1);

      start = words_queued;
      phase = 0;
      while (words_queued - start < RANDOM_WORDS) begin
         if (phase < 12) base = fixed_radix[phase];
         else if ($urandom_range(0, 4) != 0) base = $urandom_range(BASE_MIN, BASE_MAX);
         else base = $urandom_range(0, 127);
         set_radix(base);
         texts = $urandom_range(4, 16);
         repeat (texts) make_text(base, 1'b1);
         // leave a text open so the next radix applies mid-text
         if ($urandom_range(0, 3) == 0) make_text(base, 1'b0);
         phase++;
      end
      push_word(8'h00, 1'b1);

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_numbers.size() == 0) begin
         $display("radix_text_to_integer_tb passed");
      end else begin
         $display("radix_text_to_integer_tb failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/rtt_pkg.sv
rtl/rtt_digit.sv
rtl/rtt_accum.sv
rtl/radix_text_to_integer.sv
rtl/rtt_checker.sv
verif/radix_text_to_integer_tb.sv
